// ===== rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and constants for the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int OPERAND_WIDTH_DEF = 32;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0] res_den;
      logic [1:0]  status;
   } rsp_type;

endpackage

// ===== rtl/rau_mul.sv =====
// ----------------------------------------------------------------------------
// rau_mul
// registered unsigned magnitude multiplier, one product per cycle
// ----------------------------------------------------------------------------
module rau_mul
   import rau_pkg::*;
#(
   parameter int W = OPERAND_WIDTH_DEF
) (
   input  logic           clock,
   input  logic [W-1:0]   mul_a,
   input  logic [W-1:0]   mul_b,
   output logic [2*W-1:0] mul_p_ff
);

   logic [2*W-1:0] mul_p_in;

   // single product, registered
   assign mul_p_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      mul_p_ff <= mul_p_in;
   end

endmodule

// ===== rtl/rau_divstep.sv =====
// ----------------------------------------------------------------------------
// rau_divstep
// shared restoring shift-subtract step used for remainder and quotient
// ----------------------------------------------------------------------------
module rau_divstep
   import rau_pkg::*;
#(
   parameter int DW = 2*OPERAND_WIDTH_DEF
) (
   input  logic [DW-1:0] rem_cur,
   input  logic [DW-1:0] quo_cur,
   input  logic [DW-1:0] divisor,
   output logic [DW-1:0] rem_nxt,
   output logic [DW-1:0] quo_nxt
);

   logic [DW:0] trial;

   // shift in next dividend bit, subtract if it fits
   always_comb begin
      trial = {rem_cur, quo_cur[DW-1]};
      if (trial >= {1'b0, divisor}) begin
         rem_nxt = DW'(trial - {1'b0, divisor});
         quo_nxt = {quo_cur[DW-2:0], 1'b1};
      end else begin
         rem_nxt = trial[DW-1:0];
         quo_nxt = {quo_cur[DW-2:0], 1'b0};
      end
   end

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// fraction add, subtract, multiply and divide with euclidean gcd reduction
// ----------------------------------------------------------------------------
// channel  | ports                 | handshake
// request  | start, req_data       | accepted when start and not busy
// response | rsp_valid, rsp_data   | one cycle strobe, no backpressure
//
// sequence: products and sum, then each euclid step is one remainder on the
// shared shift-subtract unit, then two DW-bit quotients (DW = 2*OPERAND_WIDTH).
// zero denominators answer in the cycle after accept.
// reset clears the sequencer; busy stays high from accept to the strobe, except for zero denominator answers.
module rational_arithmetic_unit
   import rau_pkg::*;
#(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int W  = OPERAND_WIDTH;
   localparam int DW = 2*W;
   localparam int CW = $clog2(DW+1);

   typedef enum logic [3:0] {
      S_IDLE, S_M0, S_M1, S_M2, S_M3, S_SUM, S_GCD, S_QN, S_QD, S_CHK
   } state_type;

   state_type state_ff;
   logic [1:0] op_ff;
   logic [W-1:0] anm_ff, adm_ff, bnm_ff, bdm_ff;
   logic an_s_ff, ad_s_ff, bn_s_ff, bd_s_ff;
   logic [DW-1:0] p0_ff, p1_ff, nmag_ff, dmag_ff, x_ff, y_ff;
   logic nneg_ff, dneg_ff;
   logic [DW-1:0] rem_ff, quo_ff;
   logic [CW-1:0] cnt_ff;
   logic [DW-1:0] qn_ff;
   logic busy_ff, rsp_valid_ff;
   logic rsp_valid_in;
   logic in_err_w;
   rsp_type rsp_ff;

   // operand split to sign-magnitude
   function automatic logic [W:0] mag_of(input logic [31:0] raw);
      logic [W-1:0] v;
      v = raw[W-1:0];
      return v[W-1] ? ({1'b0, ~v} + (W+1)'(1)) : {1'b0, v};
   endfunction

   logic [W:0] anm_w, adm_w, bnm_w, bdm_w;
   assign anm_w = mag_of(req_data.a_num);
   assign adm_w = mag_of(req_data.a_den);
   assign bnm_w = mag_of(req_data.b_num);
   assign bdm_w = mag_of(req_data.b_den);

   // zero denominator or divide by zero on the incoming transaction
   assign in_err_w = (adm_w == '0) || (bdm_w == '0) ||
                     (req_data.operation == OP_DIV && bnm_w == '0);

   // response strobe on an error accept or at the final check
   assign rsp_valid_in = (state_ff == S_IDLE && start && in_err_w) ||
                         (state_ff == S_CHK);

   // shared multiplier operand select
   logic [W-1:0] ma, mb;
   logic [DW-1:0] mp;
   always_comb begin
      ma = anm_ff;
      mb = bdm_ff;
      case (state_ff)
         S_M1: begin
            ma = (op_ff == OP_ADD || op_ff == OP_SUB) ? bnm_ff :
                 (op_ff == OP_MUL) ? anm_ff : anm_ff;
            mb = (op_ff == OP_ADD || op_ff == OP_SUB) ? adm_ff :
                 (op_ff == OP_MUL) ? bnm_ff : bdm_ff;
         end
         S_M2: begin
            ma = adm_ff;
            mb = (op_ff == OP_DIV) ? bnm_ff : bdm_ff;
         end
         default: begin
            ma = anm_ff;
            mb = bdm_ff;
         end
      endcase
   end

   rau_mul #(.W(W)) u_mul (.clock(clock), .mul_a(ma), .mul_b(mb), .mul_p_ff(mp));

   // shared divider step
   logic [DW-1:0] rem_nx, quo_nx, dvs;
   always_comb begin
      case (state_ff)
         S_QN, S_QD: dvs = x_ff;
         default:    dvs = y_ff;
      endcase
   end
   rau_divstep #(.DW(DW)) u_div (.rem_cur(rem_ff), .quo_cur(quo_ff), .divisor(dvs),
                                  .rem_nxt(rem_nx), .quo_nxt(quo_nx));

   // sign-magnitude sum of cross products
   logic sa, sb;
   logic [DW-1:0] sum_mag;
   logic sum_neg;
   always_comb begin
      sa = an_s_ff ^ bd_s_ff;
      sb = (bn_s_ff ^ (op_ff == OP_SUB)) ^ ad_s_ff;
      if (sa == sb) begin
         sum_mag = p0_ff + p1_ff;
         sum_neg = sa;
      end else if (p0_ff >= p1_ff) begin
         sum_mag = p0_ff - p1_ff;
         sum_neg = sa;
      end else begin
         sum_mag = p1_ff - p0_ff;
         sum_neg = sb;
      end
      if (sum_mag == '0) sum_neg = 1'b0;
   end

   // overflow check on reduced values
   logic rneg, ovf;
   logic [DW-1:0] lim;
   always_comb begin
      rneg = (nneg_ff != dneg_ff) && (qn_ff != '0);
      lim  = DW'(1) << (W-1);
      ovf  = (quo_ff > lim - DW'(1)) ||
             (rneg ? (qn_ff > lim) : (qn_ff > lim - DW'(1)));
   end

   logic [W-1:0] num_w;
   assign num_w = rneg ? W'(~qn_ff + DW'(1)) : qn_ff[W-1:0];

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff  <= req_data.operation;
                  anm_ff <= anm_w[W-1:0]; adm_ff <= adm_w[W-1:0];
                  bnm_ff <= bnm_w[W-1:0]; bdm_ff <= bdm_w[W-1:0];
                  an_s_ff <= req_data.a_num[W-1]; ad_s_ff <= req_data.a_den[W-1];
                  bn_s_ff <= req_data.b_num[W-1]; bd_s_ff <= req_data.b_den[W-1];
                  busy_ff <= !in_err_w;
                  if (in_err_w) begin
                     rsp_ff <= '{res_num: '0, res_den: '0, status: ST_ZERO_DEN};
                  end else begin
                     state_ff <= S_M0;
                  end
               end
            end
            S_M0: state_ff <= S_M1;
            S_M1: begin
               p0_ff    <= mp;
               state_ff <= S_M2;
            end
            S_M2: begin
               p1_ff    <= mp;
               state_ff <= S_M3;
            end
            S_M3: begin
               dmag_ff  <= mp;
               dneg_ff  <= (op_ff == OP_DIV) ? (ad_s_ff ^ bn_s_ff) : (ad_s_ff ^ bd_s_ff);
               state_ff <= S_SUM;
            end
            S_SUM: begin
               if (op_ff == OP_ADD || op_ff == OP_SUB) begin
                  nmag_ff <= sum_mag; nneg_ff <= sum_neg;
                  x_ff    <= sum_mag;
               end else if (op_ff == OP_MUL) begin
                  nmag_ff <= p1_ff; nneg_ff <= an_s_ff ^ bn_s_ff;
                  x_ff    <= p1_ff;
               end else begin
                  nmag_ff <= p0_ff; nneg_ff <= an_s_ff ^ bd_s_ff;
                  x_ff    <= p0_ff;
               end
               y_ff   <= dmag_ff;
               rem_ff <= '0;
               quo_ff <= (op_ff == OP_ADD || op_ff == OP_SUB) ? sum_mag :
                         (op_ff == OP_MUL) ? p1_ff : p0_ff;
               cnt_ff <= '0;
               state_ff <= S_GCD;
            end
            S_GCD: begin
               if (y_ff == '0) begin
                  rem_ff <= '0; quo_ff <= nmag_ff; cnt_ff <= '0;
                  state_ff <= S_QN;
               end else if (cnt_ff == CW'(DW)) begin
                  x_ff <= y_ff; y_ff <= rem_ff;
                  quo_ff <= y_ff; rem_ff <= '0; cnt_ff <= '0;
               end else begin
                  rem_ff <= rem_nx; quo_ff <= quo_nx;
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            S_QN: begin
               if (cnt_ff == CW'(DW)) begin
                  qn_ff  <= quo_ff;
                  rem_ff <= '0; quo_ff <= dmag_ff; cnt_ff <= '0;
                  state_ff <= S_QD;
               end else begin
                  rem_ff <= rem_nx; quo_ff <= quo_nx;
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            S_QD: begin
               if (cnt_ff == CW'(DW)) begin
                  state_ff <= S_CHK;
               end else begin
                  rem_ff <= rem_nx; quo_ff <= quo_nx;
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            S_CHK: begin
               if (ovf)
                  rsp_ff <= '{res_num: '0, res_den: '0, status: ST_OVERFLOW};
               else
                  rsp_ff <= '{res_num: 32'(signed'(num_w)),
                              res_den: 31'(quo_ff[W-2:0]), status: ST_OK};
               busy_ff      <= 1'b0;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/rau_checker.sv =====
// ----------------------------------------------------------------------------
// rau_checker
// port-level checks for the rational arithmetic unit
// ----------------------------------------------------------------------------
module rau_checker
   import rau_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // accepted transaction raises busy or answers at once
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid)) else $error("accept lost");

   // no response without a transaction in flight
   a_noresp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start))) else $error("stray response");

   // error responses carry zero fields
   a_errzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |->
      (rsp_data.res_num == '0 && rsp_data.res_den == '0)) else $error("error fields");

   // ok responses have a positive denominator
   a_okden: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_OK) |-> (rsp_data.res_den != '0))
      else $error("zero denominator");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);

// ===== dv/rational_arithmetic_unit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_checker
// watches the request and response channels, predicts each reduced fraction
// from the accepted operands and compares it field by field
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_checker
   import rau_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count,
   output int      rsp_count
);

   rsp_type fraction_queue[$];

   // signed 32-bit field to sign and magnitude
   function automatic void split_sign(input logic [31:0] v, output bit neg,
                                      output logic [63:0] mag);
      neg = v[31];
      mag = {32'd0, (v[31] ? (~v + 32'd1) : v)};
   endfunction

   // signed sum of two sign-magnitude values
   function automatic void sum_signed(input bit xn, input logic [63:0] xm,
                                      input bit yn, input logic [63:0] ym,
                                      output bit rn, output logic [63:0] rm);
      if (xn == yn) begin
         rm = xm + ym;
         rn = xn;
      end else if (xm >= ym) begin
         rm = xm - ym;
         rn = xn;
      end else begin
         rm = ym - xm;
         rn = yn;
      end
      if (rm == 0) rn = 0;
   endfunction

   // exact reduced fraction for one transaction
   function automatic rsp_type reduce_fraction(input req_type r);
      rsp_type     o;
      bit          an, ad, bn, bd, pn, qn, nn, neg;
      logic [63:0] am, adm, bm, bdm, pm, qm, nm, dm, g, x, y, t;
      split_sign(r.a_num, an, am);
      split_sign(r.a_den, ad, adm);
      split_sign(r.b_num, bn, bm);
      split_sign(r.b_den, bd, bdm);
      o = '0;
      if (adm == 0 || bdm == 0 || (op_type'(r.operation) == OP_DIV && bm == 0)) begin
         o.status = ST_ZERO_DEN;
         return o;
      end
      case (op_type'(r.operation))
         OP_ADD, OP_SUB: begin
            if (op_type'(r.operation) == OP_SUB) bn = !bn;
            pm = am * bdm;
            pn = (an != bd) && pm != 0;
            qm = bm * adm;
            qn = (bn != ad) && qm != 0;
            sum_signed(pn, pm, qn, qm, nn, nm);
            dm = adm * bdm;
            neg = nn != (ad != bd);
         end
         OP_MUL: begin
            nm = am * bm;
            dm = adm * bdm;
            neg = (an != bn) != (ad != bd);
         end
         default: begin
            nm = am * bdm;
            dm = adm * bm;
            neg = (an != bd) != (ad != bn);
         end
      endcase
      if (nm == 0) neg = 0;
      x = nm;
      y = dm;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      g = x;
      nm = nm / g;
      dm = dm / g;
      if (dm > 64'h7fff_ffff || (neg ? nm > 64'h8000_0000 : nm > 64'h7fff_ffff)) begin
         o.status = ST_OVERFLOW;
         return o;
      end
      o.res_num = neg ? 32'(-nm) : 32'(nm);
      o.res_den = 31'(dm);
      o.status  = ST_OK;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %0d: %s got %0h want %0h", rsp_count, what, got, want);
      fail_count++;
   endtask

   assign pending_count = fraction_queue.size();

   initial begin
      fail_count = 0;
      rsp_count  = 0;
   end

   // predict on accept, compare on strobe
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (fraction_queue.size() == 0) begin
               report_mismatch("unexpected response", 32'(rsp_data), 0);
            end else begin
               want = fraction_queue.pop_front();
               if (rsp_data.res_num !== want.res_num)
                  report_mismatch("res_num", rsp_data.res_num, want.res_num);
               if (rsp_data.res_den !== want.res_den)
                  report_mismatch("res_den", 32'(rsp_data.res_den), 32'(want.res_den));
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            end
            rsp_count++;
         end
         if (start && !busy) fraction_queue.push_back(reduce_fraction(req_data));
      end
   end

endmodule

// ===== dv/rational_arithmetic_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb
// drives directed and random fraction transactions with random idle gaps;
// the checker predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
   import rau_pkg::*;

   localparam int RANDOM_COUNT = 700;
   localparam int STALL_LIMIT  = 40000;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_data;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      rsp_count;
   int      stall_cycles;
   int      sent_count;
   bit      steady;

   rational_arithmetic_unit dut (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   rational_arithmetic_unit_checker checker_inst (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count),
      .rsp_count(rsp_count)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // watchdog on cycles with no accepted transaction and no response
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // random operand with weight on edge values and small magnitudes
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'(int'($urandom_range(0, 6)) - 3);
         3, 4, 5: return 32'(int'($urandom_range(0, 2000)) - 1000);
         6: return 32'(int'($urandom_range(0, 200000)) - 100000);
         default: return $urandom;
      endcase
   endfunction

   // hold one transaction until accepted, optional idle before it
   task automatic send_fraction(input op_type op, input logic [31:0] an,
                                input logic [31:0] ad, input logic [31:0] bn,
                                input logic [31:0] bd);
      bit idle;
      bit taken;
      idle = !steady && ($urandom_range(0, 99) < 35);
      if (idle) begin
         start <= 0;
         while (idle) begin
            @(posedge clock);
            idle = ($urandom_range(0, 99) < 35);
         end
      end
      req_data <= '{operation: op, a_num: an, a_den: ad, b_num: bn, b_den: bd};
      start    <= 1;
      // busy is stable between edges, so sample it mid-cycle
      taken = 0;
      while (!taken) begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end
      sent_count++;
   endtask

   initial begin
      op_type op;
      stall_cycles = 0;
      sent_count   = 0;
      steady       = 0;
      reset    = 1;
      start    = 0;
      req_data = '0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: each operation, extremes and error cases
      for (int k = 0; k < 4; k++) begin
         op = op_type'(k);
         send_fraction(op, 32'd1, 32'd2, 32'd1, 32'd3);
         send_fraction(op, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
      end
      send_fraction(OP_ADD, 32'd5, 32'd0, 32'd1, 32'd1);
      send_fraction(OP_MUL, 32'd5, 32'd1, 32'd1, 32'd0);
      send_fraction(OP_DIV, 32'd5, 32'd7, 32'd0, 32'd3);
      send_fraction(OP_SUB, 32'd3, 32'd4, 32'd3, 32'd4);
      send_fraction(OP_MUL, 32'd0, 32'hffff_fff9, 32'd9, 32'd2);
      send_fraction(OP_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
      send_fraction(OP_DIV, 32'd1, 32'h7fff_ffff, 32'd2, 32'h7fff_ffff);
      send_fraction(OP_MUL, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1);
      send_fraction(OP_DIV, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1);
      send_fraction(OP_SUB, 32'hffff_fffe, 32'hffff_fffc, 32'd6, 32'hffff_fff7);
      send_fraction(OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

      // random transactions, a stretch in the middle without idling
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         steady = (i >= 300 && i < 400);
         op = op_type'($urandom_range(0, 3));
         send_fraction(op, pick_operand(), pick_operand(), pick_operand(),
                       pick_operand());
      end
      start <= 0;

      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("covered %0d transactions over all four operations, %0d responses",
               sent_count, rsp_count);
      $display("including zero denominators, zero results and overflowing sums");
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/rau_pkg.sv
rtl/rau_mul.sv
rtl/rau_divstep.sv
rtl/rational_arithmetic_unit.sv
rtl/rau_checker.sv
dv/rational_arithmetic_unit_checker.sv
dv/rational_arithmetic_unit_tb.sv
